// ===== design/frt_pkg.sv =====
`default_nettype none

package frt_pkg;

  localparam int CFG_W     = 7;
  localparam int CFG_MAX   = (1 << CFG_W) - 1;
  localparam int TW        = 2 * CFG_W;
  localparam int PIX_W     = 24;
  localparam int PAD_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIR    = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [TW-1:0]    addr;
    logic [PIX_W-1:0] wdata;
    logic [PAD_W-1:0] pad;
    logic             last;
  } mem_req_t;

  typedef struct packed {
    logic             last;
    logic [PAD_W-1:0] pad;
    logic [PIX_W-1:0] pixel;
  } res_t;

endpackage

`default_nettype wire

// ===== design/frt_store.sv =====
`default_nettype none

module frt_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                     clk,
  input  wire frt_pkg::mem_req_t        req,
  output logic [frt_pkg::PIX_W-1:0]     rd_data
);

  logic [frt_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

// ===== design/frt_seq.sv =====
`default_nettype none

module frt_seq #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int CW         = 13
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          accept,
  input  wire logic                          command,
  input  wire logic [frt_pkg::PIX_W-1:0]     pixel,
  input  wire logic [frt_pkg::CFG_W-1:0]     cfg_width,
  input  wire logic [frt_pkg::CFG_W-1:0]     cfg_height,
  input  wire logic                          cfg_dir,
  output frt_pkg::mem_req_t                  req
);

  localparam int EFF_W = (MAX_WIDTH  < frt_pkg::CFG_MAX) ? MAX_WIDTH  : frt_pkg::CFG_MAX;
  localparam int EFF_H = (MAX_HEIGHT < frt_pkg::CFG_MAX) ? MAX_HEIGHT : frt_pkg::CFG_MAX;
  localparam int TW    = frt_pkg::TW;
  localparam int NW    = frt_pkg::CFG_W;

  logic [CW-1:0] load_count_r, load_count_nxt;
  logic [NW-1:0] out_row_r, out_row_nxt;
  logic [NW-1:0] out_col_r, out_col_nxt;
  logic          done_r, done_nxt;

  logic [NW-1:0] w, h, srow, scol;
  logic [TW-1:0] total, lc_ext, rd_addr;
  logic          do_load, do_emit, row_end, last;

  // zero acts as one, oversize clamps to the store geometry
  assign w = (cfg_width == '0) ? NW'(1) :
             (cfg_width > NW'(EFF_W)) ? NW'(EFF_W) : cfg_width;
  assign h = (cfg_height == '0) ? NW'(1) :
             (cfg_height > NW'(EFF_H)) ? NW'(EFF_H) : cfg_height;

  assign total  = TW'(w) * TW'(h);
  assign lc_ext = TW'(load_count_r);

  assign do_load = accept && (command == frt_pkg::CMD_LOAD) && !done_r && (lc_ext < total);
  assign do_emit = accept && (command == frt_pkg::CMD_EMIT) && !done_r && (lc_ext >= total)
                   && (out_row_r < w) && (out_col_r < h);

  always_comb begin
    if (cfg_dir == frt_pkg::DIR_CW) begin
      srow = out_col_r;
      scol = w - NW'(1) - out_row_r;
    end else begin
      srow = h - NW'(1) - out_col_r;
      scol = out_row_r;
    end
  end

  assign rd_addr = TW'(srow) * TW'(w) + TW'(scol);
  assign row_end = (out_col_r == h - NW'(1));
  assign last    = row_end && (out_row_r == w - NW'(1));

  always_comb begin
    req.we    = do_load;
    req.re    = do_emit;
    req.addr  = do_load ? lc_ext : rd_addr;
    req.wdata = pixel;
    // (4 - 3h mod 4) mod 4 equals h mod 4
    req.pad   = row_end ? h[frt_pkg::PAD_W-1:0] : '0;
    req.last  = last;
  end

  always_comb begin
    load_count_nxt = load_count_r;
    out_row_nxt    = out_row_r;
    out_col_nxt    = out_col_r;
    done_nxt       = done_r;
    if (do_load) begin
      load_count_nxt = load_count_r + CW'(1);
    end
    if (do_emit) begin
      if (last) begin
        done_nxt = 1'b1;
      end else if (row_end) begin
        out_col_nxt = '0;
        out_row_nxt = out_row_r + NW'(1);
      end else begin
        out_col_nxt = out_col_r + NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_count_r <= '0;
      out_row_r    <= '0;
      out_col_r    <= '0;
      done_r       <= 1'b0;
    end else begin
      load_count_r <= load_count_nxt;
      out_row_r    <= out_row_nxt;
      out_col_r    <= out_col_nxt;
      done_r       <= done_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/frt_obuf.sv =====
`default_nettype none

module frt_obuf (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire frt_pkg::mem_req_t             req,
  input  wire logic [frt_pkg::PIX_W-1:0]     rd_data,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output frt_pkg::res_t                      out_data,
  output logic                               in_ready
);

  logic                       p_r;
  logic [frt_pkg::PAD_W-1:0]  p_pad_r;
  logic                       p_last_r;
  logic                       o_v_r, o_v_nxt;
  logic                       s_v_r, s_v_nxt;
  frt_pkg::res_t              o_r, o_nxt;
  frt_pkg::res_t              s_r, s_nxt;
  frt_pkg::res_t              fresh;
  logic                       fire;
  logic [1:0]                 cnt;

  assign fire = o_v_r && out_ready;
  // results in flight or held, after this cycle's pop
  assign cnt  = 2'(p_r) + 2'(o_v_r) + 2'(s_v_r) - 2'(fire);
  assign in_ready = (cnt < 2'd2);

  assign fresh.pixel = rd_data;
  assign fresh.pad   = p_pad_r;
  assign fresh.last  = p_last_r;

  always_comb begin
    o_v_nxt = o_v_r;
    o_nxt   = o_r;
    s_v_nxt = s_v_r;
    s_nxt   = s_r;
    if (fire) begin
      o_v_nxt = s_v_r;
      o_nxt   = s_r;
      s_v_nxt = 1'b0;
    end
    if (p_r) begin
      if (!o_v_nxt) begin
        o_v_nxt = 1'b1;
        o_nxt   = fresh;
      end else begin
        s_v_nxt = 1'b1;
        s_nxt   = fresh;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r   <= 1'b0;
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      p_r   <= req.re;
      o_v_r <= o_v_nxt;
      s_v_r <= s_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_pad_r  <= req.pad;
    p_last_r <= req.last;
    o_r      <= o_nxt;
    s_r      <= s_nxt;
  end

  assign out_valid = o_v_r;
  assign out_data  = o_r;

endmodule

`default_nettype wire

// ===== design/frame_rotate_quarter_turn.sv =====
// Quarter-turn rotation of a 24-bit image held in an on-chip frame store.
// Input stream: in_tuser selects the request kind (0 load, 1 emit); in_tdata
// carries blue, green, red of a source pixel for loads. Loads fill the store
// in raster order until width*height pixels are in; further loads are dropped.
// Emits, once the frame is full, each return one rotated pixel in raster order
// on the output stream; emits that come early or after the last pixel give
// nothing. out_tdata holds blue, green, red and the row pad count (zero bytes
// ending the rotated row), out_tlast flags the final pixel of the image.
// Throughput is one request per clock in both directions while the receiver
// keeps up. An emit's address multiply and store read feed the store's read
// register, then the output register. A two-entry output buffer (register
// plus skid) absorbs the read in flight, so in_tready drops once the receiver
// holds off and the held results plus the read in flight reach two. cfg_we
// writes cfg_wdata to register cfg_addr (0 width, 1 height, 2 direction); the
// user does so while the block is idle, which the block does not enforce.
// Reset clears the counters and the output buffer and restores 64x64,
// direction 0; a new frame starts only after reset. Store contents persist.
`default_nettype none

module frame_rotate_quarter_turn #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [23:0]                       in_tdata,   // blue, green, red
  input  wire logic                              in_tuser,   // command
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [31:0]                            out_tdata,  // blue, green, red, pad_bytes
  output logic                                   out_tlast,
  input  wire logic                              cfg_we,
  input  wire logic [frt_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  wire logic [frt_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int EFF_W = (MAX_WIDTH  < frt_pkg::CFG_MAX) ? MAX_WIDTH  : frt_pkg::CFG_MAX;
  localparam int EFF_H = (MAX_HEIGHT < frt_pkg::CFG_MAX) ? MAX_HEIGHT : frt_pkg::CFG_MAX;
  localparam int DEPTH = EFF_W * EFF_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [frt_pkg::CFG_W-1:0] width_r, height_r;
  logic                      dir_r;
  logic                      accept;
  frt_pkg::mem_req_t         req;
  frt_pkg::res_t             res;
  logic [frt_pkg::PIX_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= frt_pkg::CFG_W'(64);
      height_r <= frt_pkg::CFG_W'(64);
      dir_r    <= frt_pkg::DIR_CW;
    end else if (cfg_we) begin
      case (cfg_addr)
        frt_pkg::REG_WIDTH:  width_r  <= cfg_wdata;
        frt_pkg::REG_HEIGHT: height_r <= cfg_wdata;
        frt_pkg::REG_DIR:    dir_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  frt_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .command    (in_tuser),
    .pixel      (in_tdata),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_dir    (dir_r),
    .req        (req)
  );

  frt_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  frt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_data   (rd_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (res),
    .in_ready  (in_tready)
  );

  assign out_tdata = {6'd0, res.pad, res.pixel};
  assign out_tlast = res.last;

  a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.we && req.re))
    else $error("store read and write in one cycle");

  a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
    req.re |-> ##2 out_tvalid)
    else $error("store read did not reach the output");

  a_nothing_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("result after final pixel");

endmodule

`default_nettype wire

// ===== sim/tb_frame_rotate_quarter_turn.sv =====
module tb_frame_rotate_quarter_turn;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W       = 64;
  localparam int MAX_H       = 64;
  localparam int STORE_DEPTH = MAX_W * MAX_H;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 200000;

  localparam logic [frt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  class rotate_scoreboard;
    logic [frt_pkg::PIX_W-1:0] frame_mem [STORE_DEPTH];
    int unsigned loaded;
    int unsigned row_pos;
    int unsigned col_pos;
    bit image_done;
    logic [frt_pkg::CFG_W-1:0] width_reg;
    logic [frt_pkg::CFG_W-1:0] height_reg;
    logic dir_reg;
    frt_pkg::res_t pending[$];
    int unsigned n_predicted;
    int unsigned n_errors;

    function new();
      loaded = 0;
      row_pos = 0;
      col_pos = 0;
      image_done = 0;
      width_reg = 7'd64;
      height_reg = 7'd64;
      dir_reg = frt_pkg::DIR_CW;
      n_predicted = 0;
      n_errors = 0;
    endfunction

    function void write_reg(logic [frt_pkg::CFG_IDX_W-1:0] idx,
                            logic [frt_pkg::CFG_W-1:0] val);
      case (idx)
        frt_pkg::REG_WIDTH: width_reg = val;
        frt_pkg::REG_HEIGHT: height_reg = val;
        frt_pkg::REG_DIR: dir_reg = val[0];
        default: ;
      endcase
    endfunction

    // zero acts as one, oversize clamps to the store limit
    function int unsigned clamp_dim(logic [frt_pkg::CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function int unsigned img_w();
      return clamp_dim(width_reg, MAX_W);
    endfunction

    function int unsigned img_h();
      return clamp_dim(height_reg, MAX_H);
    endfunction

    function bit frame_full();
      return loaded >= img_w() * img_h();
    endfunction

    function bit emit_finishes();
      int unsigned w;
      int unsigned h;
      w = img_w();
      h = img_h();
      return !image_done && frame_full() && row_pos == w - 1 && col_pos == h - 1;
    endfunction

    function void note_request(logic cmd, logic [frt_pkg::PIX_W-1:0] pix);
      int unsigned w;
      int unsigned h;
      int unsigned src_row;
      int unsigned src_col;
      frt_pkg::res_t r;
      w = img_w();
      h = img_h();
      if (cmd == frt_pkg::CMD_LOAD) begin
        if (!image_done && loaded < w * h) begin
          frame_mem[loaded] = pix;
          loaded++;
        end
        return;
      end
      if (image_done || loaded < w * h || row_pos >= w || col_pos >= h) return;
      if (dir_reg == frt_pkg::DIR_CW) begin
        src_row = col_pos;
        src_col = w - 1 - row_pos;
      end else begin
        src_row = h - 1 - col_pos;
        src_col = row_pos;
      end
      r.pixel = frame_mem[src_row * w + src_col];
      r.pad = (col_pos == h - 1) ? frt_pkg::PAD_W'((4 - (3 * h) % 4) % 4) : '0;
      r.last = (col_pos == h - 1) && (row_pos == w - 1);
      pending.push_back(r);
      n_predicted++;
      if (r.last) begin
        image_done = 1;
      end else if (col_pos == h - 1) begin
        col_pos = 0;
        row_pos++;
      end else begin
        col_pos++;
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_pixel(logic [31:0] data, logic tl);
      frt_pkg::res_t want;
      if (pending.size() == 0) begin
        $display("%0t: pixel expected none actual %h last %b", $time, data, tl);
        n_errors++;
        return;
      end
      want = pending.pop_front();
      compare_field("blue", want.pixel[7:0], data[7:0]);
      compare_field("green", want.pixel[15:8], data[15:8]);
      compare_field("red", want.pixel[23:16], data[23:16]);
      compare_field("pad_bytes", 8'(want.pad), 8'(data[25:24]));
      compare_field("last_pixel", 8'(want.last), 8'(tl));
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [23:0]                   in_tdata;   // blue, green, red
  logic                          in_tuser;   // command
  logic                          out_tvalid;
  logic                          out_tready;
  logic [31:0]                   out_tdata;  // blue, green, red, pad_bytes
  logic                          out_tlast;  // last_pixel
  logic                          cfg_we;
  logic [frt_pkg::CFG_IDX_W-1:0] cfg_addr;
  logic [frt_pkg::CFG_W-1:0]     cfg_wdata;

  rotate_scoreboard sb;
  bit quiet;
  bit long_hold_req;
  int unsigned cycles;

  frame_rotate_quarter_turn uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
  end

  task automatic send_request(input logic cmd, input logic [23:0] pix);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 17);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = pix;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, pix);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [frt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frt_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // mostly well-formed: fill the frame, then read out up to target pixels, or the whole image with finish
  task automatic run_phase(input logic [frt_pkg::CFG_W-1:0] w,
                           input logic [frt_pkg::CFG_W-1:0] h,
                           input logic d, input int unsigned target,
                           input int unsigned tail, input bit finish, input bit hold);
    int unsigned base;
    int unsigned n;
    logic cmd;
    drain();
    write_reg(frt_pkg::REG_WIDTH, w);
    write_reg(frt_pkg::REG_HEIGHT, h);
    write_reg(frt_pkg::REG_DIR, d);
    if (hold) long_hold_req = 1;
    base = sb.n_predicted;
    n = 0;
    while (n < target * 4 + 600 &&
           (finish ? !sb.image_done : (sb.n_predicted - base < target))) begin
      if (sb.frame_full())
        cmd = ($urandom_range(0, 7) == 0) ? frt_pkg::CMD_LOAD : frt_pkg::CMD_EMIT;
      else
        cmd = ($urandom_range(0, 7) == 0) ? frt_pkg::CMD_EMIT : frt_pkg::CMD_LOAD;
      if (!finish && cmd == frt_pkg::CMD_EMIT && sb.emit_finishes()) cmd = frt_pkg::CMD_LOAD;
      send_request(cmd, 24'($urandom()));
      n++;
    end
    repeat (tail)
      send_request(($urandom_range(0, 1) == 0) ? frt_pkg::CMD_LOAD : frt_pkg::CMD_EMIT,
                   24'($urandom()));
  endtask

  initial begin
    sb = new();
    quiet = 0;
    long_hold_req = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = frt_pkg::CMD_LOAD;
    cfg_we = 1'b0;
    cfg_addr = frt_pkg::REG_WIDTH;
    cfg_wdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // early emit under the reset size
    send_request(frt_pkg::CMD_EMIT, 24'h000000);

    drain();
    write_reg(frt_pkg::REG_WIDTH, 7'd2);
    write_reg(frt_pkg::REG_HEIGHT, 7'd3);
    write_reg(frt_pkg::REG_DIR, frt_pkg::DIR_CCW);
    write_reg(REG_UNUSED, 7'h7f);
    send_request(frt_pkg::CMD_LOAD, 24'h000000);
    send_request(frt_pkg::CMD_LOAD, 24'hffffff);
    send_request(frt_pkg::CMD_EMIT, 24'hffffff);
    send_request(frt_pkg::CMD_LOAD, 24'h0000ff);
    send_request(frt_pkg::CMD_LOAD, 24'h00ff00);
    send_request(frt_pkg::CMD_LOAD, 24'hff0000);
    send_request(frt_pkg::CMD_LOAD, 24'h5aa5c3);
    send_request(frt_pkg::CMD_LOAD, 24'h123456);  // frame already full
    repeat (3) send_request(frt_pkg::CMD_EMIT, 24'h000000);

    // zero width, oversize height: read position now outside the image
    drain();
    write_reg(frt_pkg::REG_WIDTH, 7'd0);
    write_reg(frt_pkg::REG_HEIGHT, 7'd127);
    send_request(frt_pkg::CMD_EMIT, 24'h000000);

    drain();
    write_reg(frt_pkg::REG_WIDTH, 7'd2);
    write_reg(frt_pkg::REG_HEIGHT, 7'd4);
    write_reg(frt_pkg::REG_DIR, frt_pkg::DIR_CW);
    send_request(frt_pkg::CMD_LOAD, 24'ha5a5a5);
    send_request(frt_pkg::CMD_LOAD, 24'h3c3c3c);
    repeat (2) send_request(frt_pkg::CMD_EMIT, 24'h000000);

    run_phase(7'd3, 7'd64,
              ($urandom_range(0, 1) == 0) ? frt_pkg::DIR_CW : frt_pkg::DIR_CCW, 62, 0, 0, 0);
    run_phase(7'd127, 7'd3, frt_pkg::DIR_CW, 60, 0, 0, 1);
    run_phase(7'd64, 7'd4, frt_pkg::DIR_CCW, 40, 0, 0, 0);
    run_phase(7'd40, 7'd0,
              ($urandom_range(0, 1) == 0) ? frt_pkg::DIR_CW : frt_pkg::DIR_CCW, 6, 0, 0, 0);
    run_phase(7'd50, 7'd2,
              ($urandom_range(0, 1) == 0) ? frt_pkg::DIR_CW : frt_pkg::DIR_CCW, 10, 0, 0, 0);
    run_phase(7'd1, 7'd5, frt_pkg::DIR_CW, 0, 12, 0, 0);
    drain();
    quiet = 1;
    run_phase(7'd45, 7'd5,
              ($urandom_range(0, 1) == 0) ? frt_pkg::DIR_CW : frt_pkg::DIR_CCW, 0, 12, 1, 0);

    drain();
    repeat (20) @(negedge clk);
    if (sb.n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
